@@ src/fasd_pkg.sv @@
// Package of the full ASCII shift decoder: types, register indexes and the punctuation table.
`timescale 1ns / 1ps
`default_nettype none
package fasd_pkg;

	typedef logic [6:0] char_t;

	// Configuration register indexes, in the order of the register list.
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_SHIFT_CONTROL = 2'd0;
	localparam reg_idx_t REG_SHIFT_PERCENT = 2'd1;
	localparam reg_idx_t REG_SHIFT_SLASH   = 2'd2;
	localparam reg_idx_t REG_SHIFT_PLUS    = 2'd3;

	// Which shift is pending.
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_CONTROL = 2'd0;
	localparam kind_t KIND_PERCENT = 2'd1;
	localparam kind_t KIND_SLASH   = 2'd2;
	localparam kind_t KIND_PLUS    = 2'd3;

	localparam char_t RST_SHIFT_CONTROL = 7'd36;
	localparam char_t RST_SHIFT_PERCENT = 7'd37;
	localparam char_t RST_SHIFT_SLASH   = 7'd47;
	localparam char_t RST_SHIFT_PLUS    = 7'd43;

	localparam char_t CHAR_UPPER_A = 7'd65;
	localparam char_t CHAR_UPPER_Z = 7'd90;
	localparam char_t CTRL_OFFSET  = 7'd64;
	localparam char_t CASE_OFFSET  = 7'd32;

	typedef char_t [3:0] shift_set_t;

	typedef struct packed {
		logic  pending_valid;
		kind_t pending_kind;
		logic  dropping;
	} fasd_state_t;

	typedef struct packed {
		logic  emit;
		char_t out_char;
		logic  format_error;
		logic  end_of_string;
	} fasd_result_t;

	// Punctuation and control table for the second shift, indexed by letter minus 'A'.
	function automatic char_t percent_map(input logic [4:0] idx);
		char_t r;
		unique case (idx)
			5'd0, 5'd1, 5'd2, 5'd3, 5'd4:      r = 7'd27 + {2'b00, idx};
			5'd5, 5'd6, 5'd7, 5'd8, 5'd9:      r = 7'd54 + {2'b00, idx};
			5'd10, 5'd11, 5'd12, 5'd13, 5'd14: r = 7'd81 + {2'b00, idx};
			5'd15, 5'd16, 5'd17, 5'd18, 5'd19: r = 7'd108 + {2'b00, idx};
			5'd20:                             r = 7'd0;
			5'd21:                             r = 7'd64;
			5'd22:                             r = 7'd96;
			default:                           r = 7'd127;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ src/fasd_ifs.sv @@
// Channel interfaces of the full ASCII shift decoder: input, result and configuration.
`timescale 1ns / 1ps
`default_nettype none
interface fasd_in_if;
	logic                valid;
	logic                ready;
	fasd_pkg::char_t     in_char;
	logic                last_of_string;
	modport source (output valid, in_char, last_of_string, input ready);
	modport sink   (input valid, in_char, last_of_string, output ready);
endinterface

interface fasd_out_if;
	logic                valid;
	logic                ready;
	fasd_pkg::char_t     out_char;
	logic                format_error;
	logic                end_of_string;
	modport source (output valid, out_char, format_error, end_of_string, input ready);
	modport sink   (input valid, out_char, format_error, end_of_string, output ready);
endinterface

interface fasd_cfg_if;
	logic                 valid;
	logic                 ready;
	fasd_pkg::reg_idx_t   index;
	fasd_pkg::char_t      data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/full_ascii_shift_decoder.sv @@
// Top level of the full ASCII shift decoder: input register, decode and result register.
//
// Usage: characters of a symbol's text arrive as words on din, each with a last-of-string
// mark. Shift characters produce no result of their own; the following letter is mapped
// to its full ASCII value and leaves on dout. A bad follower, or a shift character that
// ends the string, produces one error word with end_of_string set, and the remaining
// words of that string are discarded.
// Configuration: four shift characters are written on cfg, index 0 to 3, and may only be
// written while the decoder is idle. cfg is always ready.
// Path: a word accepted on din is held in the input register, decoded from there and
// written into the result register, which drives dout.
// Throughput: one word per cycle while dout is not stalled; the decode is a single pass of
// comparators and a small table between the input register and the result register.
// Reset: arst_n clears the pipeline, the shift state and restores the default shift
// characters ('$', '%', '/', '+').
// Stalls: the result register holds its word while dout.ready is low; the input register
// holds the next word behind it, and din.ready falls only when both are occupied.
`timescale 1ns / 1ps
`default_nettype none
module full_ascii_shift_decoder (
	input  wire logic   clk,
	input  wire logic   arst_n,
	fasd_in_if.sink     din,
	fasd_out_if.source  dout,
	fasd_cfg_if.sink    cfg
);

	// Shift character registers.
	fasd_pkg::shift_set_t   shifts_q;

	// Input stage.
	logic                   valid_s1;
	fasd_pkg::char_t        char_s1;
	logic                   last_s1;

	// Decoder state carried from one word to the next.
	fasd_pkg::fasd_state_t  state_q;
	fasd_pkg::fasd_state_t  state_next;
	fasd_pkg::fasd_result_t res;

	// Result register.
	logic                   out_valid_q;
	fasd_pkg::char_t        out_char_q;
	logic                   out_err_q;
	logic                   out_eos_q;

	logic                   load_out;
	logic                   advance;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shifts_q[fasd_pkg::REG_SHIFT_CONTROL] <= fasd_pkg::RST_SHIFT_CONTROL;
			shifts_q[fasd_pkg::REG_SHIFT_PERCENT] <= fasd_pkg::RST_SHIFT_PERCENT;
			shifts_q[fasd_pkg::REG_SHIFT_SLASH]   <= fasd_pkg::RST_SHIFT_SLASH;
			shifts_q[fasd_pkg::REG_SHIFT_PLUS]    <= fasd_pkg::RST_SHIFT_PLUS;
		end else if (cfg.valid) begin
			shifts_q[cfg.index] <= cfg.data;
		end
	end

	// The result register can take a new word when it is empty or being drained;
	// the input stage moves on whenever that is so, whether or not a result follows.
	assign load_out  = !out_valid_q || dout.ready;
	assign advance   = valid_s1 && load_out;
	assign din.ready = !valid_s1 || load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.ready && din.valid) begin
			char_s1 <= din.in_char;
			last_s1 <= din.last_of_string;
		end
	end

	fasd_map u_map (
		.in_char (char_s1),
		.last    (last_s1),
		.shifts  (shifts_q),
		.st      (state_q),
		.st_next (state_next),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_next;
			end
			if (load_out) begin
				out_valid_q <= advance && res.emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			out_char_q <= res.out_char;
			out_err_q  <= res.format_error;
			out_eos_q  <= res.end_of_string;
		end
	end

	assign dout.valid         = out_valid_q;
	assign dout.out_char      = out_char_q;
	assign dout.format_error  = out_err_q;
	assign dout.end_of_string = out_eos_q;

endmodule
`default_nettype wire

@@ src/fasd_map.sv @@
// Decode logic for one character: shift matching, follower mapping and next state.
`timescale 1ns / 1ps
`default_nettype none
module fasd_map (
	input  wire fasd_pkg::char_t      in_char,
	input  wire logic                 last,
	input  wire fasd_pkg::shift_set_t shifts,
	input  wire fasd_pkg::fasd_state_t st,
	output fasd_pkg::fasd_state_t     st_next,
	output fasd_pkg::fasd_result_t    res
);

	logic                  hit;
	fasd_pkg::kind_t       hit_kind;
	logic                  is_letter;
	logic [4:0]            letter_off;
	fasd_pkg::char_t       mapped;

	// The lowest-numbered matching shift register wins.
	always_comb begin
		hit      = 1'b1;
		hit_kind = fasd_pkg::KIND_CONTROL;
		priority if (in_char == shifts[fasd_pkg::REG_SHIFT_CONTROL]) begin
			hit_kind = fasd_pkg::KIND_CONTROL;
		end else if (in_char == shifts[fasd_pkg::REG_SHIFT_PERCENT]) begin
			hit_kind = fasd_pkg::KIND_PERCENT;
		end else if (in_char == shifts[fasd_pkg::REG_SHIFT_SLASH]) begin
			hit_kind = fasd_pkg::KIND_SLASH;
		end else if (in_char == shifts[fasd_pkg::REG_SHIFT_PLUS]) begin
			hit_kind = fasd_pkg::KIND_PLUS;
		end else begin
			hit = 1'b0;
		end
	end

	assign is_letter  = (in_char >= fasd_pkg::CHAR_UPPER_A) && (in_char <= fasd_pkg::CHAR_UPPER_Z);
	assign letter_off = 5'(in_char - fasd_pkg::CHAR_UPPER_A);

	always_comb begin
		unique case (st.pending_kind)
			fasd_pkg::KIND_CONTROL: mapped = in_char - fasd_pkg::CTRL_OFFSET;
			fasd_pkg::KIND_PERCENT: mapped = fasd_pkg::percent_map(letter_off);
			fasd_pkg::KIND_SLASH:   mapped = in_char - fasd_pkg::CASE_OFFSET;
			default:                mapped = in_char + fasd_pkg::CASE_OFFSET;
		endcase
	end

	always_comb begin
		st_next = st;
		res     = '0;
		if (st.dropping) begin
			if (last) begin
				st_next = '0;
			end
		end else if (st.pending_valid) begin
			st_next.pending_valid = 1'b0;
			if (!is_letter) begin
				res.emit          = 1'b1;
				res.format_error  = 1'b1;
				res.end_of_string = 1'b1;
				if (last) begin
					st_next = '0;
				end else begin
					st_next.dropping = 1'b1;
				end
			end else begin
				res.emit          = 1'b1;
				res.out_char      = mapped;
				res.end_of_string = last;
				if (last) begin
					st_next = '0;
				end
			end
		end else if (hit) begin
			if (last) begin
				res.emit          = 1'b1;
				res.format_error  = 1'b1;
				res.end_of_string = 1'b1;
				st_next           = '0;
			end else begin
				st_next.pending_valid = 1'b1;
				st_next.pending_kind  = hit_kind;
			end
		end else begin
			res.emit          = 1'b1;
			res.out_char      = in_char;
			res.end_of_string = last;
			if (last) begin
				st_next = '0;
			end
		end
	end

endmodule
`default_nettype wire
